// ===== src/nsh_pkg.sv =====
// ----------------------------------------------------------------------------
// nsh_pkg: shared types, constants and functions
// Holds the FNV-1a constants, the normalizer state type and the byte
// classification functions used by the normalized SQL hash block.
// ----------------------------------------------------------------------------
package nsh_pkg;

    localparam int unsigned HashW = 64;
    localparam int unsigned ByteW = 8;
    localparam int unsigned MixSlots = 3;

    localparam logic [HashW-1:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;
    // The FNV prime is 2^40 + 0x1b3.
    localparam int unsigned FNV_SHIFT = 40;
    localparam logic [8:0] FNV_MULT_LO = 9'h1b3;

    localparam logic [ByteW-1:0] CH_NUL = 8'h00;
    localparam logic [ByteW-1:0] CH_TAB = 8'h09;
    localparam logic [ByteW-1:0] CH_LF = 8'h0a;
    localparam logic [ByteW-1:0] CH_CR = 8'h0d;
    localparam logic [ByteW-1:0] CH_SPACE = 8'h20;
    localparam logic [ByteW-1:0] CH_DQUOTE = 8'h22;
    localparam logic [ByteW-1:0] CH_SQUOTE = 8'h27;
    localparam logic [ByteW-1:0] CH_LPAREN = 8'h28;
    localparam logic [ByteW-1:0] CH_RPAREN = 8'h29;
    localparam logic [ByteW-1:0] CH_STAR = 8'h2a;
    localparam logic [ByteW-1:0] CH_COMMA = 8'h2c;
    localparam logic [ByteW-1:0] CH_DASH = 8'h2d;
    localparam logic [ByteW-1:0] CH_SLASH = 8'h2f;
    localparam logic [ByteW-1:0] CH_SEMI = 8'h3b;
    localparam logic [ByteW-1:0] CH_UPPER_A = 8'h41;
    localparam logic [ByteW-1:0] CH_UPPER_Z = 8'h5a;
    localparam logic [ByteW-1:0] CH_TILDE = 8'h7e;
    localparam logic [ByteW-1:0] CASE_OFFSET = 8'h20;

    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_SINGLE = 2'd1,
        Q_DOUBLE = 2'd2
    } t_quote;

    typedef enum logic [1:0] {
        C_NONE  = 2'd0,
        C_LINE  = 2'd1,
        C_BLOCK = 2'd2
    } t_cmt;

    typedef struct packed {
        t_quote quote;
        t_cmt   cmt;
        logic   after_space;
        logic   space_pending;
    } t_lex;

    localparam t_lex LEX_RESET = '{
        quote: Q_NONE, cmt: C_NONE, after_space: 1'b1, space_pending: 1'b0
    };

    typedef struct packed {
        t_lex             st;
        logic             skip;
        logic             mix_vld;
        logic [ByteW-1:0] mix_byte;
    } t_handle;

    typedef struct packed {
        logic [MixSlots-1:0]            vld;
        logic [MixSlots-1:0][ByteW-1:0] bytes;
    } t_mix_req;

    function automatic logic is_blank(input logic [ByteW-1:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    // A space before one of these bytes is dropped.
    function automatic logic drops_space(input logic [ByteW-1:0] b);
        return (b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_COMMA) ||
               (b == CH_SEMI) || (b == CH_NUL);
    endfunction

    // Handles byte c with look-ahead byte nxt.
    function automatic t_handle handle(input logic [ByteW-1:0] c,
                                       input logic [ByteW-1:0] nxt,
                                       input t_lex st);
        t_handle    r;
        logic [ByteW-1:0] open_q;
        r.st = st;
        r.skip = 1'b0;
        r.mix_vld = 1'b0;
        r.mix_byte = c;
        open_q = (st.quote == Q_SINGLE) ? CH_SQUOTE :
                 (st.quote == Q_DOUBLE) ? CH_DQUOTE : CH_NUL;
        if (st.cmt == C_NONE && st.quote == Q_NONE && c == CH_DASH && nxt == CH_DASH) begin
            r.st.cmt = C_LINE;
            r.skip = 1'b1;
        end else if (st.cmt == C_NONE && st.quote == Q_NONE && c == CH_SLASH &&
                     nxt == CH_STAR) begin
            r.st.cmt = C_BLOCK;
            r.skip = 1'b1;
        end else if (st.cmt == C_LINE) begin
            if (c == CH_LF) begin
                r.st.cmt = C_NONE;
            end
        end else if (st.cmt == C_BLOCK) begin
            if (c == CH_STAR && nxt == CH_SLASH) begin
                r.st.cmt = C_NONE;
                r.skip = 1'b1;
            end
        end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            r.mix_vld = 1'b1;
            if (st.quote != Q_NONE && open_q == c && nxt == c) begin
                r.skip = 1'b1;
            end else begin
                if (st.quote != Q_NONE && open_q == c) begin
                    r.st.quote = Q_NONE;
                end else if (st.quote == Q_NONE) begin
                    r.st.quote = (c == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
                end
                r.st.after_space = 1'b0;
            end
        end else if (st.quote != Q_NONE) begin
            r.mix_vld = 1'b1;
            r.st.after_space = 1'b0;
        end else if (c < CH_SPACE || c > CH_TILDE) begin
            r.mix_vld = 1'b0;
        end else if (c == CH_SPACE) begin
            if (!st.after_space) begin
                r.st.space_pending = 1'b1;
                r.st.after_space = 1'b1;
            end
        end else if (c == CH_SEMI) begin
            r.st.after_space = 1'b1;
        end else begin
            r.mix_vld = 1'b1;
            if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
                r.mix_byte = c + CASE_OFFSET;
            end
            r.st.after_space = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== src/nsh_in_if.sv =====
// ----------------------------------------------------------------------------
// nsh_in_if: text byte channel
// Valid/ready channel that carries one text byte and its last-byte mark.
// ----------------------------------------------------------------------------
interface nsh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       is_last;

    modport source (output valid, output text_byte, output is_last, input ready);
    modport sink (input valid, input text_byte, input is_last, output ready);
endinterface

// ===== src/nsh_out_if.sv =====
// ----------------------------------------------------------------------------
// nsh_out_if: hash result channel
// Valid/ready channel that carries one 64-bit hash value.
// ----------------------------------------------------------------------------
interface nsh_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink (input valid, input hash_value, output ready);
endinterface

// ===== src/nsh_mix.sv =====
// ----------------------------------------------------------------------------
// nsh_mix: FNV-1a round
// One hash round: xor the byte in, then multiply by the FNV prime as a
// shift plus a narrow constant product.
// ----------------------------------------------------------------------------
module nsh_mix (
    input  logic [nsh_pkg::HashW-1:0] i_acc,
    input  logic [nsh_pkg::ByteW-1:0] i_byte,
    output logic [nsh_pkg::HashW-1:0] o_acc
);

    logic [nsh_pkg::HashW-1:0] x;
    logic [nsh_pkg::HashW-1:0] lo_prod;

    assign x = i_acc ^ {{(nsh_pkg::HashW - nsh_pkg::ByteW){1'b0}}, i_byte};
    assign lo_prod = nsh_pkg::HashW'(x * {{(nsh_pkg::HashW - 9){1'b0}},
                                          nsh_pkg::FNV_MULT_LO});
    assign o_acc = (x << nsh_pkg::FNV_SHIFT) + lo_prod;

endmodule

// ===== src/nsh_lex.sv =====
// ----------------------------------------------------------------------------
// nsh_lex: SQL text normalizer
// Keeps the quote, comment and space state and the one-byte look-ahead,
// and turns each accepted byte into up to three bytes to be hashed.
// ----------------------------------------------------------------------------
module nsh_lex (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic [nsh_pkg::ByteW-1:0] i_byte,
    input  logic                      i_last,
    output nsh_pkg::t_mix_req         o_req
);

    nsh_pkg::t_lex             r_st, n_st;
    logic [nsh_pkg::ByteW-1:0] r_held, n_held;
    logic                      r_held_vld, n_held_vld;

    nsh_pkg::t_handle          h_first, h_end;
    nsh_pkg::t_lex             s_mid;
    logic                      skip;

    always_comb begin
        h_first = nsh_pkg::handle(r_held, i_byte, r_st);
        s_mid = r_held_vld ? h_first.st : r_st;
        skip = r_held_vld & h_first.skip;
        o_req.vld = '0;
        o_req.bytes[0] = h_first.mix_byte;
        o_req.bytes[1] = nsh_pkg::CH_SPACE;
        o_req.vld[0] = r_held_vld & h_first.mix_vld;
        n_held = r_held;
        n_held_vld = 1'b0;
        if (!skip) begin
            if (s_mid.space_pending && !nsh_pkg::is_blank(i_byte)) begin
                o_req.vld[1] = !nsh_pkg::drops_space(i_byte);
                s_mid.space_pending = 1'b0;
            end
            n_held = i_byte;
            n_held_vld = 1'b1;
        end
        h_end = nsh_pkg::handle(n_held, nsh_pkg::CH_NUL, s_mid);
        o_req.bytes[2] = h_end.mix_byte;
        o_req.vld[2] = i_last & n_held_vld & h_end.mix_vld;
        n_st = s_mid;
        if (i_last) begin
            n_st = nsh_pkg::LEX_RESET;
            n_held = nsh_pkg::CH_NUL;
            n_held_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= nsh_pkg::LEX_RESET;
            r_held_vld <= 1'b0;
            r_held <= nsh_pkg::CH_NUL;
        end else if (i_accept) begin
            r_st <= n_st;
            r_held_vld <= n_held_vld;
            r_held <= n_held;
        end
    end

endmodule

// ===== src/normalized_sql_fnv1a_hash.sv =====
// ----------------------------------------------------------------------------
// normalized_sql_fnv1a_hash: 64-bit FNV-1a hash of normalized SQL text
// Top level: input channel, normalizer, shared hash round and result register.
// ----------------------------------------------------------------------------
// Usage:
// SQL text enters one byte per item on i_in; the final byte of a statement
// carries is_last. Comments, stray control bytes, semicolons and redundant
// blanks are removed, letters outside quotes are lower-cased, and the rest
// is hashed with 64-bit FNV-1a. One hash item per statement leaves on o_out
// after the last byte.
// Each accepted byte yields up to three hash rounds, run one per cycle on a
// single shared round unit. A byte with no rounds and no last mark leaves the
// block idle; any other byte moves it to the mix state, which runs the rounds
// and then a closing step. On a last byte the closing step moves the hash
// into the result register. i_in.ready is high only out of reset and while no
// rounds are outstanding.
// The result register is separate, so the next statement may start while a
// hash waits; if a second hash finishes while the receiver still stalls,
// the block holds, with i_in.ready low, until the register is taken.
// Reset (synchronous, active low) returns all state to the start of a
// statement and drops any result not yet taken.
// ----------------------------------------------------------------------------
module normalized_sql_fnv1a_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nsh_in_if.sink      i_in,
    nsh_out_if.source   o_out
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_MIX  = 2'b10
    } t_state;

    t_state                              r_state, n_state;
    nsh_pkg::t_mix_req                   r_req, n_req;
    logic                                r_last, n_last;
    logic [nsh_pkg::HashW-1:0]           r_hash, n_hash;
    logic                                r_out_vld, n_out_vld;
    logic [nsh_pkg::HashW-1:0]           r_out_hash, n_out_hash;

    nsh_pkg::t_mix_req                   lex_req;
    logic                                accept;
    logic [nsh_pkg::ByteW-1:0]           mix_byte;
    logic [nsh_pkg::HashW-1:0]           mix_acc;
    logic                                out_free;

    assign accept = i_in.valid & i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE) & i_rst_n;
    assign o_out.valid = r_out_vld;
    assign o_out.hash_value = r_out_hash;
    assign out_free = !r_out_vld || o_out.ready;

    nsh_lex u_lex (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in.text_byte),
        .i_last   (i_in.is_last),
        .o_req    (lex_req)
    );

    always_comb begin
        priority if (r_req.vld[0]) begin
            mix_byte = r_req.bytes[0];
        end else if (r_req.vld[1]) begin
            mix_byte = r_req.bytes[1];
        end else begin
            mix_byte = r_req.bytes[2];
        end
    end

    nsh_mix u_mix (
        .i_acc  (r_hash),
        .i_byte (mix_byte),
        .o_acc  (mix_acc)
    );

    always_comb begin
        n_state = r_state;
        n_req = r_req;
        n_last = r_last;
        n_hash = r_hash;
        n_out_vld = r_out_vld && !o_out.ready;
        n_out_hash = r_out_hash;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_req = lex_req;
                    n_last = i_in.is_last;
                    if (i_in.is_last || lex_req.vld != '0) begin
                        n_state = ST_MIX;
                    end
                end
            end
            ST_MIX: begin
                if (r_req.vld != '0) begin
                    n_hash = mix_acc;
                    priority if (r_req.vld[0]) begin
                        n_req.vld[0] = 1'b0;
                    end else if (r_req.vld[1]) begin
                        n_req.vld[1] = 1'b0;
                    end else begin
                        n_req.vld[2] = 1'b0;
                    end
                end else if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_vld = 1'b1;
                    n_out_hash = r_hash;
                    n_hash = nsh_pkg::FNV_BASIS;
                    n_last = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_req <= '0;
            r_last <= 1'b0;
            r_hash <= nsh_pkg::FNV_BASIS;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_req <= n_req;
            r_last <= n_last;
            r_hash <= n_hash;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_hash <= n_out_hash;
    end

    a_idle_no_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_req.vld == '0))
        else $error("rounds outstanding while ready");

    a_plain_byte_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_in.is_last && lex_req.vld == '0) |=> (r_state == ST_IDLE))
        else $error("byte without rounds left the idle state");

    a_finish_restarts_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MIX && r_req.vld == '0 && r_last && out_free)
        |=> (r_hash == nsh_pkg::FNV_BASIS && r_out_vld && r_state == ST_IDLE))
        else $error("finished statement did not load result and restart hash");

    a_result_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_out.ready) |=> (r_out_vld && $stable(r_out_hash)))
        else $error("stalled result changed");

endmodule

// ===== tb/tb_normalized_sql_fnv1a_hash.sv =====
// ----------------------------------------------------------------------------
// tb_normalized_sql_fnv1a_hash: self-checking bench for the SQL text hasher
// Feeds statements byte by byte over the input channel, in random bursts,
// while the result channel stalls on its own pattern. A model of the
// normalizer inside the bench predicts the hash of every accepted
// statement, and each hash item taken from the block is compared with
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb_normalized_sql_fnv1a_hash;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] FNV_MULT = 64'h0000_0100_0000_01b3;
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned RANDOM_BYTES = 550;
    localparam int unsigned TAIL_CYCLES = 20;
    localparam string PUNCT = "(),;*=-/.<>+_";

    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       drain;
    } t_text_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    nsh_in_if  in_ch ();
    nsh_out_if out_ch ();

    normalized_sql_fnv1a_hash dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    t_text_item  text_q[$];
    logic [7:0]  stmt_q[$];
    logic [63:0] hash_expect_q[$];
    int unsigned n_bytes_total = 0;
    int unsigned n_bytes_taken = 0;
    int unsigned fail_cnt = 0;
    int unsigned cycle_cnt = 0;
    bit          byte_taken = 1'b0;

    // Normalizer state of the predictor.
    logic [63:0]     p_hash;
    nsh_pkg::t_quote p_quote;
    nsh_pkg::t_cmt   p_cmt;
    logic            p_after_sp;
    logic [7:0]      p_held;
    logic            p_held_vld;
    logic            p_space_pend;

    function automatic void clear_predictor();
        p_hash       = nsh_pkg::FNV_BASIS;
        p_quote      = nsh_pkg::Q_NONE;
        p_cmt        = nsh_pkg::C_NONE;
        p_after_sp   = 1'b1;
        p_held       = 8'h00;
        p_held_vld   = 1'b0;
        p_space_pend = 1'b0;
    endfunction

    function automatic void fnv_round(input logic [7:0] b);
        p_hash = (p_hash ^ {56'd0, b}) * FNV_MULT;
    endfunction

    // Lexes byte c with look-ahead nxt; returns 1 when nxt is used up as
    // the second byte of a pair.
    function automatic bit lex_char(input logic [7:0] c, input logic [7:0] nxt);
        logic [7:0] open_q;
        logic [7:0] lc;
        open_q = (p_quote == nsh_pkg::Q_SINGLE) ? nsh_pkg::CH_SQUOTE :
                 (p_quote == nsh_pkg::Q_DOUBLE) ? nsh_pkg::CH_DQUOTE : nsh_pkg::CH_NUL;
        lc = c;
        if (p_cmt == nsh_pkg::C_NONE && p_quote == nsh_pkg::Q_NONE) begin
            if (c == nsh_pkg::CH_DASH && nxt == nsh_pkg::CH_DASH) begin
                p_cmt = nsh_pkg::C_LINE;
                return 1'b1;
            end
            if (c == nsh_pkg::CH_SLASH && nxt == nsh_pkg::CH_STAR) begin
                p_cmt = nsh_pkg::C_BLOCK;
                return 1'b1;
            end
        end
        if (p_cmt == nsh_pkg::C_LINE) begin
            if (c == nsh_pkg::CH_LF) p_cmt = nsh_pkg::C_NONE;
            return 1'b0;
        end
        if (p_cmt == nsh_pkg::C_BLOCK) begin
            if (c == nsh_pkg::CH_STAR && nxt == nsh_pkg::CH_SLASH) begin
                p_cmt = nsh_pkg::C_NONE;
                return 1'b1;
            end
            return 1'b0;
        end
        if (c == nsh_pkg::CH_SQUOTE || c == nsh_pkg::CH_DQUOTE) begin
            if (p_quote != nsh_pkg::Q_NONE && open_q == c) begin
                if (nxt == c) begin
                    fnv_round(c);
                    return 1'b1;
                end
                p_quote = nsh_pkg::Q_NONE;
            end else if (p_quote == nsh_pkg::Q_NONE) begin
                p_quote = (c == nsh_pkg::CH_SQUOTE) ? nsh_pkg::Q_SINGLE : nsh_pkg::Q_DOUBLE;
            end
            fnv_round(c);
            p_after_sp = 1'b0;
            return 1'b0;
        end
        if (p_quote != nsh_pkg::Q_NONE) begin
            fnv_round(c);
            p_after_sp = 1'b0;
            return 1'b0;
        end
        if (c < nsh_pkg::CH_SPACE || c > nsh_pkg::CH_TILDE) return 1'b0;
        if (c == nsh_pkg::CH_SPACE) begin
            if (!p_after_sp) begin
                p_space_pend = 1'b1;
                p_after_sp   = 1'b1;
            end
            return 1'b0;
        end
        if (c == nsh_pkg::CH_SEMI) begin
            p_after_sp = 1'b1;
            return 1'b0;
        end
        if (c >= nsh_pkg::CH_UPPER_A && c <= nsh_pkg::CH_UPPER_Z) begin
            lc = c + nsh_pkg::CASE_OFFSET;
        end
        fnv_round(lc);
        p_after_sp = 1'b0;
        return 1'b0;
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic last);
        bit skip;
        bit blank;
        skip  = 1'b0;
        blank = (b == nsh_pkg::CH_SPACE) || (b >= nsh_pkg::CH_TAB && b <= nsh_pkg::CH_CR);
        if (p_held_vld) begin
            skip = lex_char(p_held, b);
            p_held_vld = 1'b0;
        end
        if (!skip) begin
            if (p_space_pend && !blank) begin
                if (!(b == nsh_pkg::CH_LPAREN || b == nsh_pkg::CH_RPAREN ||
                      b == nsh_pkg::CH_COMMA || b == nsh_pkg::CH_SEMI ||
                      b == nsh_pkg::CH_NUL)) begin
                    fnv_round(nsh_pkg::CH_SPACE);
                end
                p_space_pend = 1'b0;
            end
            p_held     = b;
            p_held_vld = 1'b1;
        end
        if (last) begin
            if (p_held_vld) begin
                void'(lex_char(p_held, nsh_pkg::CH_NUL));
                p_held_vld = 1'b0;
            end
            hash_expect_q.push_back(p_hash);
            clear_predictor();
        end
    endtask

    // Statement building.
    task automatic push_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++) stmt_q.push_back(s[i]);
    endtask

    task automatic flush_stmt(input bit drain);
        int i;
        t_text_item it;
        if (stmt_q.size() == 0) stmt_q.push_back("x");
        for (i = 0; i < stmt_q.size(); i++) begin
            it.b     = stmt_q[i];
            it.last  = (i == stmt_q.size() - 1);
            it.drain = drain && (i == 0);
            text_q.push_back(it);
        end
        n_bytes_total += stmt_q.size();
        stmt_q.delete();
    endtask

    task automatic gen_statement(input bit drain);
        int n_tok;
        int t;
        int k;
        int len;
        logic [7:0] q;
        if ($urandom_range(0, 7) == 0) begin
            len = $urandom_range(1, 6);
            for (k = 0; k < len; k++) stmt_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            n_tok = $urandom_range(1, 7);
            for (t = 0; t < n_tok; t++) begin
                case ($urandom_range(0, 13))
                    0, 1, 2, 3: begin
                        len = $urandom_range(1, 5);
                        for (k = 0; k < len; k++) begin
                            case ($urandom_range(0, 4))
                                0, 1: stmt_q.push_back(8'($urandom_range(8'h61, 8'h7a)));
                                2, 3: stmt_q.push_back(8'($urandom_range(8'h41, 8'h5a)));
                                default: stmt_q.push_back(8'($urandom_range(8'h30, 8'h39)));
                            endcase
                        end
                    end
                    4, 5, 6: begin
                        len = $urandom_range(1, 3);
                        for (k = 0; k < len; k++) begin
                            case ($urandom_range(0, 7))
                                0: stmt_q.push_back(nsh_pkg::CH_TAB);
                                1: stmt_q.push_back(nsh_pkg::CH_LF);
                                2: stmt_q.push_back(8'($urandom_range(8'h0b, 8'h0d)));
                                default: stmt_q.push_back(nsh_pkg::CH_SPACE);
                            endcase
                        end
                    end
                    7, 8: stmt_q.push_back(PUNCT[$urandom_range(0, PUNCT.len() - 1)]);
                    9: begin
                        q = $urandom_range(0, 1) ? nsh_pkg::CH_SQUOTE : nsh_pkg::CH_DQUOTE;
                        stmt_q.push_back(q);
                        len = $urandom_range(0, 4);
                        for (k = 0; k < len; k++) begin
                            case ($urandom_range(0, 5))
                                0: begin
                                    stmt_q.push_back(q);
                                    stmt_q.push_back(q);
                                end
                                1: stmt_q.push_back(8'($urandom_range(0, 255)));
                                default: stmt_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
                            endcase
                        end
                        if ($urandom_range(0, 6) != 0) stmt_q.push_back(q);
                    end
                    10: begin
                        push_str("--");
                        len = $urandom_range(0, 4);
                        for (k = 0; k < len; k++)
                            stmt_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
                        if ($urandom_range(0, 4) != 0) stmt_q.push_back(nsh_pkg::CH_LF);
                    end
                    11: begin
                        push_str("/*");
                        len = $urandom_range(0, 4);
                        for (k = 0; k < len; k++) begin
                            case ($urandom_range(0, 3))
                                0: stmt_q.push_back(nsh_pkg::CH_STAR);
                                1: stmt_q.push_back(nsh_pkg::CH_SLASH);
                                default: stmt_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
                            endcase
                        end
                        if ($urandom_range(0, 4) != 0) push_str("*/");
                    end
                    12: stmt_q.push_back(nsh_pkg::CH_NUL);
                    default: stmt_q.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
        flush_stmt(drain);
    endtask

    // Sender: bursts of random length separated by random gaps.
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(negedge i_clk) begin : drive_text
        t_text_item it;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || byte_taken) begin
            byte_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (text_q.size() == 0 ||
                         (text_q[0].drain && hash_expect_q.size() != 0)) begin
                in_ch.valid <= 1'b0;
            end else begin
                it = text_q.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.text_byte <= it.b;
                in_ch.is_last   <= it.last;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 3))
                        1: gap_left = $urandom_range(1, 3);
                        2: gap_left = $urandom_range(4, 12);
                        default: gap_left = 0;
                    endcase
                end
            end
        end
    end

    always @(posedge i_clk) begin : take_text
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            predict_byte(in_ch.text_byte, in_ch.is_last);
            byte_taken = 1'b1;
            n_bytes_taken++;
        end
    end

    // Receiver: ready follows a random 16-bit pattern that changes now and then.
    logic [15:0] stall_pat = 16'hffff;
    int unsigned stall_idx = 0;
    int unsigned pat_life = 0;

    always @(negedge i_clk) begin : drive_ready
        if (pat_life == 0) begin
            pat_life = $urandom_range(16, 80);
            case ($urandom_range(0, 3))
                0: stall_pat = 16'hffff;
                1: stall_pat = 16'($urandom);
                2: stall_pat = 16'($urandom & $urandom);
                default: stall_pat = ~16'($urandom & $urandom);
            endcase
            if (stall_pat == 16'h0000) stall_pat = 16'h0001;
        end
        out_ch.ready <= stall_pat[stall_idx % 16];
        stall_idx++;
        pat_life--;
    end

    always @(posedge i_clk) begin : check_hash
        logic [63:0] want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (hash_expect_q.size() == 0) begin
                $error("hash_value: unexpected item, expected none, actual %h",
                       out_ch.hash_value);
                fail_cnt++;
            end else begin
                want = hash_expect_q.pop_front();
                if (out_ch.hash_value !== want) begin
                    $error("hash_value mismatch: expected %h, actual %h",
                           want, out_ch.hash_value);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned n_stmt;
        in_ch.valid     = 1'b0;
        in_ch.text_byte = 8'h00;
        in_ch.is_last   = 1'b0;
        out_ch.ready    = 1'b0;
        i_rst_n         = 1'b0;
        clear_predictor();

        // Directed statements: single bytes at the extremes, a space before
        // a bracket and before a zero byte, quotes with doubled and missing
        // closers, and both kinds of comment.
        push_str("Z");
        flush_stmt(1'b0);
        stmt_q.push_back(8'hff);
        flush_stmt(1'b0);
        stmt_q.push_back(nsh_pkg::CH_NUL);
        flush_stmt(1'b0);
        push_str("a (");
        flush_stmt(1'b0);
        push_str("'x''");
        flush_stmt(1'b0);
        push_str("b --c");
        stmt_q.push_back(nsh_pkg::CH_LF);
        push_str("d");
        flush_stmt(1'b0);
        push_str("/*;*/E");
        flush_stmt(1'b0);
        push_str("\"q");
        flush_stmt(1'b0);
        push_str("a ");
        stmt_q.push_back(nsh_pkg::CH_NUL);
        flush_stmt(1'b0);

        n_stmt = 0;
        while (n_bytes_total < RANDOM_BYTES + 28) begin
            gen_statement(n_stmt % 12 == 0);
            n_stmt++;
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_bytes_taken != n_bytes_total) @(posedge i_clk);
        while (hash_expect_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
